@@ sv/nrsz_pkg.sv @@
`default_nettype none

package nrsz_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COEFF_BITS    = 2'd0,
    CFG_COEFF_COUNT   = 2'd1,
    CFG_MODULUS       = 2'd2,
    CFG_PAYLOAD_BYTES = 2'd3
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [4:0]  RST_COEFF_BITS    = 5'd11;
  localparam logic [10:0] RST_COEFF_COUNT   = 11'd509;
  localparam logic [16:0] RST_MODULUS       = 17'd2048;
  localparam logic [11:0] RST_PAYLOAD_BYTES = 12'd699;

  localparam logic [4:0]  MIN_COEFF_BITS = 5'd8;
  localparam logic [11:0] BYTES_SAT      = 12'hFFF;

  // Result queue depth; a byte can push two results at once.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);

  typedef struct packed {
    logic [15:0] coefficient;
    logic        coeff_last;
    logic        status;
  } result_t;

  // Results produced by one byte, in order r0 then r1.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

@@ sv/ntru_rq_sum_zero_unpacker.sv @@
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid / tready        tdata[7:0] data_byte, tlast last_byte
// m_axis    out  tvalid / tready        tdata[15:0] coefficient, tlast coeff_last,
//                                       tuser status
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_index_i register, cfg_data_i value
//
// A byte is decoded in the cycle of its transfer: bit buffer, coefficient extraction,
// running sum and final coefficient settle between the state registers and a four-entry
// result queue, and the first result of a byte can transfer at the next clock edge.
// Input ready is high while the queue holds two results or fewer; it drops when the
// consumer stalls, or when bytes that each yield two results outrun one output per cycle.
// Reset (asynchronous, active low) restores the defaults; config is always accepted.

module ntru_rq_sum_zero_unpacker #(
  parameter int unsigned MAX_COEFFS     = 1024,
  parameter int unsigned MAX_COEFF_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // Coefficient stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] coefficient
  output logic             m_axis_tlast,   // coeff_last
  output logic             m_axis_tuser,   // status
  // Configuration writes.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  // The buffer holds up to a coefficient less one bit plus a fresh byte.
  localparam int unsigned BufW  = MAX_COEFF_BITS + 7;
  localparam int unsigned HeldW = $clog2(BufW + 1);
  localparam int unsigned IdxW  = $clog2(MAX_COEFFS);
  localparam logic [4:0]  MaxW  = 5'(MAX_COEFF_BITS);
  localparam logic [12:0] MaxN  = 13'(MAX_COEFFS);

  // Configuration registers.
  logic [4:0]  coeff_bits_q;
  logic [10:0] coeff_count_q;
  logic [16:0] modulus_q;
  logic [11:0] payload_bytes_q;

  // Decoder state.
  logic [BufW-1:0]  buf_q, buf_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [11:0]      bytes_seen_q, bytes_seen_d;
  logic [15:0]      sum_q, sum_d;
  logic             finished_q, finished_d;

  // Work signals.
  logic             in_xfer;
  logic             room2;
  logic [4:0]       width;
  logic [12:0]      cnt_cap;
  logic [IdxW-1:0]  target;
  logic [11:0]      byte_count;
  logic [BufW-1:0]  buf_new;
  logic [HeldW-1:0] held_new;
  logic [15:0]      raw_coeff;
  logic [16:0]      red_coeff;
  logic [16:0]      sum_wide;
  logic [15:0]      final_coeff;
  logic             fin_now;
  nrsz_pkg::push_t  push;
  nrsz_pkg::result_t head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room2;
  assign in_xfer       = s_axis_tvalid && room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_bits_q    <= nrsz_pkg::RST_COEFF_BITS;
      coeff_count_q   <= nrsz_pkg::RST_COEFF_COUNT;
      modulus_q       <= nrsz_pkg::RST_MODULUS;
      payload_bytes_q <= nrsz_pkg::RST_PAYLOAD_BYTES;
    end else if (cfg_valid_i) begin
      case (nrsz_pkg::cfg_idx_e'(cfg_index_i))
        nrsz_pkg::CFG_COEFF_BITS:    coeff_bits_q    <= cfg_data_i[4:0];
        nrsz_pkg::CFG_COEFF_COUNT:   coeff_count_q   <= cfg_data_i[10:0];
        nrsz_pkg::CFG_MODULUS:       modulus_q       <= cfg_data_i;
        nrsz_pkg::CFG_PAYLOAD_BYTES: payload_bytes_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Effective coefficient width and the index of the final coefficient.
  always_comb begin
    if (coeff_bits_q < nrsz_pkg::MIN_COEFF_BITS) begin
      width = nrsz_pkg::MIN_COEFF_BITS;
    end else if (coeff_bits_q > MaxW) begin
      width = MaxW;
    end else begin
      width = coeff_bits_q;
    end
    cnt_cap = ({2'b00, coeff_count_q} > MaxN) ? MaxN : {2'b00, coeff_count_q};
    target  = (cnt_cap == '0) ? '0 : IdxW'(cnt_cap - 13'd1);
  end

  always_comb begin
    buf_d        = buf_q;
    held_d       = held_q;
    idx_d        = idx_q;
    bytes_seen_d = bytes_seen_q;
    sum_d        = sum_q;
    finished_d   = finished_q;
    push         = '0;

    byte_count = (bytes_seen_q < nrsz_pkg::BYTES_SAT) ? bytes_seen_q + 12'd1
                                                      : nrsz_pkg::BYTES_SAT;
    buf_new   = buf_q | (BufW'(s_axis_tdata) << held_q);
    held_new  = held_q + HeldW'(8);
    raw_coeff = 16'(buf_new) & (16'hFFFF >> (5'd16 - width));
    red_coeff = ({1'b0, raw_coeff} >= modulus_q) ? {1'b0, raw_coeff} - modulus_q
                                                 : {1'b0, raw_coeff};
    sum_wide  = {1'b0, sum_q} + red_coeff;
    if (sum_wide >= modulus_q) begin
      sum_wide = sum_wide - modulus_q;
    end
    final_coeff = '0;
    fin_now     = 1'b0;

    if (in_xfer) begin
      if (finished_q && !s_axis_tlast) begin
        // Trailing bytes after the polynomial are dropped.
      end else if (s_axis_tlast && (byte_count < payload_bytes_q)) begin
        push.n  = 2'd1;
        push.r0 = '{coefficient: 16'd0, coeff_last: 1'b1, status: 1'b1};
        buf_d        = '0;
        held_d       = '0;
        idx_d        = '0;
        bytes_seen_d = '0;
        sum_d        = '0;
        finished_d   = 1'b0;
      end else begin
        fin_now = finished_q;
        if (!finished_q) begin
          buf_d  = buf_new;
          held_d = held_new;
          if ((idx_q < target) && (held_new >= HeldW'(width))) begin
            buf_d   = buf_new >> width;
            held_d  = held_new - HeldW'(width);
            push.n  = 2'd1;
            push.r0 = '{coefficient: raw_coeff, coeff_last: 1'b0, status: 1'b0};
            sum_d   = sum_wide[15:0];
            idx_d   = idx_q + 1'b1;
          end
          if (idx_d >= target) begin
            final_coeff = (sum_d == '0) ? 16'd0 : 16'(modulus_q - {1'b0, sum_d});
            if (push.n == 2'd0) begin
              push.r0 = '{coefficient: final_coeff, coeff_last: 1'b1, status: 1'b0};
            end else begin
              push.r1 = '{coefficient: final_coeff, coeff_last: 1'b1, status: 1'b0};
            end
            push.n     = push.n + 2'd1;
            fin_now    = 1'b1;
            finished_d = 1'b1;
          end
        end
        if (s_axis_tlast) begin
          // Stream ended before the final coefficient: append an error.
          if (!fin_now) begin
            if (push.n == 2'd0) begin
              push.r0 = '{coefficient: 16'd0, coeff_last: 1'b1, status: 1'b1};
            end else begin
              push.r1 = '{coefficient: 16'd0, coeff_last: 1'b1, status: 1'b1};
            end
            push.n = push.n + 2'd1;
          end
          buf_d        = '0;
          held_d       = '0;
          idx_d        = '0;
          bytes_seen_d = '0;
          sum_d        = '0;
          finished_d   = 1'b0;
        end else begin
          bytes_seen_d = byte_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q        <= '0;
      held_q       <= '0;
      idx_q        <= '0;
      bytes_seen_q <= '0;
      sum_q        <= '0;
      finished_q   <= 1'b0;
    end else begin
      buf_q        <= buf_d;
      held_q       <= held_d;
      idx_q        <= idx_d;
      bytes_seen_q <= bytes_seen_d;
      sum_q        <= sum_d;
      finished_q   <= finished_d;
    end
  end

  nrsz_result_q u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room2_o (room2)
  );

  assign m_axis_tdata = head.coefficient;
  assign m_axis_tlast = head.coeff_last;
  assign m_axis_tuser = head.status;

  // A byte after completion that is not the last one yields no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && finished_q && !s_axis_tlast) |-> (push.n == 2'd0))
    else $error("result pushed for a byte after completion");

  // When two results come from one byte, the second always closes the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (push.r1.coeff_last && !push.r0.coeff_last))
    else $error("second result of a byte does not end the frame");

  // A last byte rearms the decoder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> (bytes_seen_q == '0 && !finished_q && idx_q == '0))
    else $error("decoder not rearmed after last byte");

  // Nothing is pushed without an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |-> (push.n == 2'd0))
    else $error("result pushed without an input transfer");

endmodule

`default_nettype wire

@@ sv/nrsz_result_q.sv @@
`default_nettype none

module nrsz_result_q (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nrsz_pkg::push_t push_i,
  input  wire logic            pop_i,
  output nrsz_pkg::result_t    head_o,
  output logic                 valid_o,
  output logic                 room2_o
);

  localparam int unsigned CntW = nrsz_pkg::QPTRW + 1;

  nrsz_pkg::result_t                 mem_q [nrsz_pkg::QDEPTH];
  logic [nrsz_pkg::QPTRW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [nrsz_pkg::QPTRW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic [nrsz_pkg::QPTRW-1:0]        wr_ptr_p1;
  logic                              do_pop;

  assign valid_o   = (count_q != '0);
  assign room2_o   = (count_q <= CntW'(nrsz_pkg::QDEPTH - 2));
  assign head_o    = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;
  assign wr_ptr_p1 = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.n[nrsz_pkg::QPTRW-1:0];
    rd_ptr_d = rd_ptr_q + {{(nrsz_pkg::QPTRW-1){1'b0}}, do_pop};
    count_d  = count_q + CntW'(push_i.n) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 500;
  localparam int unsigned BYTE_TARGET  = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;  // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] coefficient
  logic        m_axis_tlast;         // coeff_last
  logic        m_axis_tuser;         // status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  ntru_rq_sum_zero_unpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the frame state.
  // ---------------------------------------------------------------------------
  logic [4:0]  reg_bits;
  logic [10:0] reg_count;
  logic [16:0] reg_modulus;
  logic [11:0] reg_payload;

  logic [22:0] bit_buf;
  logic [4:0]  bits_avail;
  logic [10:0] coeffs_done;
  logic [11:0] bytes_in;
  logic [15:0] sum_mod;
  bit          frame_done;

  nrsz_pkg::result_t step_results[$];     // coefficients caused by the byte just decoded
  nrsz_pkg::result_t pending_coeffs[$];   // coefficients still to be seen on the output

  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_bytes = 0;
  bit          no_idle_phase = 1'b0;
  bit          hold_request = 1'b0;

  function automatic nrsz_pkg::result_t mk_result(logic [15:0] c, logic lst, logic st);
    nrsz_pkg::result_t r;
    r.coefficient = c;
    r.coeff_last  = lst;
    r.status      = st;
    return r;
  endfunction

  function automatic void restart_frame();
    bit_buf     = '0;
    bits_avail  = '0;
    coeffs_done = '0;
    bytes_in    = '0;
    sum_mod     = '0;
    frame_done  = 1'b0;
  endfunction

  function automatic void apply_reg(nrsz_pkg::cfg_idx_e idx, logic [16:0] val);
    case (idx)
      nrsz_pkg::CFG_COEFF_BITS:    reg_bits    = val[4:0];
      nrsz_pkg::CFG_COEFF_COUNT:   reg_count   = val[10:0];
      nrsz_pkg::CFG_MODULUS:       reg_modulus = val;
      nrsz_pkg::CFG_PAYLOAD_BYTES: reg_payload = val[11:0];
      default: ;
    endcase
  endfunction

  // Effective coefficient width after clamping to [8, 16].
  function automatic int unsigned eff_width(logic [4:0] raw);
    int unsigned w;
    w = (raw < nrsz_pkg::MIN_COEFF_BITS) ? nrsz_pkg::MIN_COEFF_BITS : raw;
    if (w > 16) w = 16;
    return w;
  endfunction

  // Decodes one accepted byte into step_results. A byte after completion
  // that is not the last one leaves step_results empty.
  function automatic void unpack_byte(logic [7:0] d, logic lst);
    int unsigned w, cnt, tgt, seen, v, s, fin, bb, held;
    step_results.delete();
    if (frame_done && !lst) return;

    seen = (bytes_in < nrsz_pkg::BYTES_SAT) ? bytes_in + 1 : nrsz_pkg::BYTES_SAT;

    // Last byte before the minimum payload length: the data is thrown away
    // and only a truncation status goes out.
    if (lst && seen < reg_payload) begin
      step_results.insert(step_results.size(), mk_result(16'd0, 1'b1, 1'b1));
      restart_frame();
      return;
    end

    if (!frame_done) begin
      w   = eff_width(reg_bits);
      cnt = (reg_count > 1024) ? 1024 : reg_count;
      tgt = (cnt == 0) ? 0 : cnt - 1;

      bb   = (bit_buf | (32'(d) << bits_avail)) & 32'h7F_FFFF;
      held = bits_avail + 8;

      if (coeffs_done < tgt && held >= w) begin
        v    = bb & ((32'd1 << w) - 1);
        bb   = bb >> w;
        held = held - w;
        step_results.insert(step_results.size(), mk_result(v[15:0], 1'b0, 1'b0));
        // One conditional subtraction on the coefficient, one on the sum.
        if (v >= reg_modulus) v = v - reg_modulus;
        s = sum_mod + v;
        if (s >= reg_modulus) s = s - reg_modulus;
        sum_mod     = s[15:0];
        coeffs_done = coeffs_done + 1;
      end
      bit_buf    = bb[22:0];
      bits_avail = held[4:0];

      // The implied final coefficient cancels the running sum.
      if (coeffs_done >= tgt) begin
        fin = (sum_mod == 0) ? 0 : (reg_modulus - sum_mod);
        step_results.insert(step_results.size(), mk_result(fin[15:0], 1'b1, 1'b0));
        frame_done = 1'b1;
      end
    end

    if (lst) begin
      // Enough bytes, but the stream stopped before the final coefficient.
      if (!frame_done)
        step_results.insert(step_results.size(), mk_result(16'd0, 1'b1, 1'b1));
      restart_frame();
    end else begin
      bytes_in = seen[11:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking. Outputs are sampled at the rising edge, before any
  // register in the design has taken its new value.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    nrsz_pkg::result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_coeffs.size() == 0) begin
        $error("unexpected coefficient transfer: coefficient %0d coeff_last %0d status %0d",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fails++;
      end else begin
        exp_r = pending_coeffs.pop_front();
        if (m_axis_tdata !== exp_r.coefficient) begin
          $error("coefficient: expected %0d, got %0d", exp_r.coefficient, m_axis_tdata);
          fails++;
        end
        if (m_axis_tlast !== exp_r.coeff_last) begin
          $error("coeff_last: expected %0d, got %0d", exp_r.coeff_last, m_axis_tlast);
          fails++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient sink. Ready alternates between runs and stalls of random
  // length. When the source asks for it, the sink holds off for a long stretch
  // so that the result queue fills and the input stream stalls.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int unsigned run_len, stall_len, i, r;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      run_len = (r < 10) ? $urandom_range(60, 120) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      i = 0;
      do begin
        @(posedge clk_i);
        i++;
      end while (i < run_len && !hold_request);
      m_axis_tready <= 1'b0;
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_len = LONG_HOLD;
      end else if (r < 85) begin
        stall_len = $urandom_range(1, 3);
      end else begin
        stall_len = $urandom_range(8, 40);
      end
      repeat (stall_len) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    nrsz_pkg::cfg_idx_e  reg_idx;
    logic [16:0]         reg_val;
    logic [7:0]          data;
    logic                lst;
    bit                  typed;      // expected coefficient written into the row
    nrsz_pkg::result_t   typed_res;
  } row_t;

  row_t stim_rows[$];

  function automatic row_t byte_row(logic [7:0] d, logic lst);
    row_t rw;
    rw.kind      = ROW_BYTE;
    rw.reg_idx   = nrsz_pkg::CFG_COEFF_BITS;
    rw.reg_val   = '0;
    rw.data      = d;
    rw.lst       = lst;
    rw.typed     = 1'b0;
    rw.typed_res = '0;
    return rw;
  endfunction

  // A last byte that must come back as a truncation status.
  function automatic row_t trunc_row(logic [7:0] d);
    row_t rw;
    rw           = byte_row(d, 1'b1);
    rw.typed     = 1'b1;
    rw.typed_res = mk_result(16'd0, 1'b1, 1'b1);
    return rw;
  endfunction

  function automatic row_t reg_row(nrsz_pkg::cfg_idx_e idx, logic [16:0] val);
    row_t rw;
    rw         = byte_row(8'd0, 1'b0);
    rw.kind    = ROW_REG;
    rw.reg_idx = idx;
    rw.reg_val = val;
    return rw;
  endfunction

  // Idle gap before a byte: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle_phase || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte, waits for its transfer and records what it should cause.
  // Valid stays high after the transfer so that back-to-back bytes need no
  // second assignment in the same step.
  task automatic offer_byte(input logic [7:0] d, input logic lst, input int unsigned gap,
                            input bit typed, input nrsz_pkg::result_t typed_res);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
    unpack_byte(d, lst);
    if (typed) begin
      pending_coeffs.insert(pending_coeffs.size(), typed_res);
    end else begin
      foreach (step_results[k]) pending_coeffs.insert(pending_coeffs.size(), step_results[k]);
    end
  endtask

  // Stops the byte stream and waits until every pending coefficient is out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Valid is left high; the caller lowers it after a group of writes.
  task automatic write_reg(input nrsz_pkg::cfg_idx_e idx, input logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  initial begin : source
    int unsigned r, w_raw, w_eff, cnt_raw, cnt_eff, tgt, need, len, i, nframes;
    int unsigned mod_val, pay_val, holds_asked;
    bit          lst;
    logic [7:0]  d;

    reg_bits    = nrsz_pkg::RST_COEFF_BITS;
    reg_count   = nrsz_pkg::RST_COEFF_COUNT;
    reg_modulus = nrsz_pkg::RST_MODULUS;
    reg_payload = nrsz_pkg::RST_PAYLOAD_BYTES;
    restart_frame();
    holds_asked = 0;

    // Directed table.
    // Reset defaults: an early last byte is a truncated payload.
    stim_rows.insert(stim_rows.size(), trunc_row(8'hFF));
    stim_rows.insert(stim_rows.size(), byte_row(8'h00, 1'b0));
    stim_rows.insert(stim_rows.size(), trunc_row(8'hFF));
    // Narrowest width, two coefficients, smallest usable modulus.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_BITS, 17'd8));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd2));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_MODULUS, 17'd128));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'd1));
    stim_rows.insert(stim_rows.size(), byte_row(8'hFF, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h5A, 1'b0));   // after completion: dropped
    stim_rows.insert(stim_rows.size(), byte_row(8'h00, 1'b1));   // last after completion
    stim_rows.insert(stim_rows.size(), byte_row(8'h00, 1'b0));   // zero sum, zero final
    stim_rows.insert(stim_rows.size(), byte_row(8'h33, 1'b1));
    // A single coefficient: the final one comes out on the first byte.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd1));
    stim_rows.insert(stim_rows.size(), byte_row(8'h81, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h7E, 1'b1));
    // Width above the top acts as 16; largest real modulus; the final
    // coefficient is completed by the last byte itself.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_BITS, 17'd31));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd3));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_MODULUS, 17'd65536));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'd2));
    stim_rows.insert(stim_rows.size(), byte_row(8'hFF, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'hFF, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h01, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h00, 1'b1));
    // Width below the bottom acts as 8, count above the top is clamped,
    // all-ones modulus and the largest payload length.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_BITS, 17'd0));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd2047));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_MODULUS, 17'h1FFFF));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'd4095));
    stim_rows.insert(stim_rows.size(), byte_row(8'hA5, 1'b0));
    stim_rows.insert(stim_rows.size(), trunc_row(8'h3C));
    // Modulus far below the coefficient range, then a stream that ends early.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_BITS, 17'd16));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd4));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_MODULUS, 17'd128));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'd1));
    stim_rows.insert(stim_rows.size(), byte_row(8'hFF, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'hFF, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h00, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h80, 1'b1));
    // Twelve-bit packing: one short frame, one that ends early.
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_BITS, 17'd12));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_COEFF_COUNT, 17'd1024));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_MODULUS, 17'd4096));
    stim_rows.insert(stim_rows.size(), reg_row(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'd3));
    stim_rows.insert(stim_rows.size(), byte_row(8'hAB, 1'b0));
    stim_rows.insert(stim_rows.size(), trunc_row(8'hCD));
    stim_rows.insert(stim_rows.size(), byte_row(8'h12, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h34, 1'b0));
    stim_rows.insert(stim_rows.size(), byte_row(8'h56, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Consecutive register rows form one write group, preceded by a drain.
    for (i = 0; i < stim_rows.size(); i++) begin
      if (stim_rows[i].kind == ROW_REG) begin
        if (i == 0 || stim_rows[i-1].kind != ROW_REG) settle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
        if (i + 1 == stim_rows.size() || stim_rows[i+1].kind != ROW_REG)
          cfg_valid_i <= 1'b0;
      end else begin
        offer_byte(stim_rows[i].data, stim_rows[i].lst, pick_gap(),
                   stim_rows[i].typed, stim_rows[i].typed_res);
      end
    end

    // Random phases: each one a fresh register setting and a few frames.
    while (sent_bytes < BYTE_TARGET) begin
      settle();

      r = $urandom_range(0, 99);
      if (r < 4)      w_raw = $urandom_range(0, 7);
      else if (r < 8) w_raw = $urandom_range(17, 31);
      else            w_raw = $urandom_range(8, 16);
      w_eff = eff_width(w_raw[4:0]);

      r = $urandom_range(0, 99);
      if (r < 75)      cnt_raw = $urandom_range(0, 24);
      else if (r < 92) cnt_raw = $urandom_range(25, 160);
      else             cnt_raw = $urandom_range(161, 2047);
      cnt_eff = (cnt_raw > 1024) ? 1024 : cnt_raw;
      tgt     = (cnt_eff == 0) ? 0 : cnt_eff - 1;
      need    = (tgt * w_eff + 7) / 8;
      if (need == 0) need = 1;

      // Mostly a modulus that keeps the sum reduced, sometimes anything.
      r = $urandom_range(0, 99);
      if (r < 80) mod_val = $urandom_range(1 << (w_eff - 1), 1 << w_eff);
      else        mod_val = $urandom_range(0, 17'h1FFFF);

      r = $urandom_range(0, 99);
      if (r < 70)      pay_val = $urandom_range(1, need);
      else if (r < 85) pay_val = $urandom_range(0, need + 4);
      else             pay_val = $urandom_range(0, 4095);

      write_reg(nrsz_pkg::CFG_COEFF_BITS, 17'(w_raw));
      write_reg(nrsz_pkg::CFG_COEFF_COUNT, 17'(cnt_raw));
      write_reg(nrsz_pkg::CFG_MODULUS, 17'(mod_val));
      write_reg(nrsz_pkg::CFG_PAYLOAD_BYTES, 17'(pay_val));
      cfg_valid_i <= 1'b0;

      no_idle_phase = ($urandom_range(0, 4) == 0);
      nframes = $urandom_range(1, 4);
      repeat (nframes) begin
        r = $urandom_range(0, 99);
        if (r < 70 && need <= 200) begin
          len = need + $urandom_range(0, 3);
          // Ask the sink for its long hold-off on a frame with plenty of
          // coefficients, so that the design fills up and stalls the input.
          if (tgt >= 6 && ((holds_asked == 0 && sent_bytes > 150) ||
                           (holds_asked == 1 && sent_bytes > 600))) begin
            hold_request = 1'b1;
            holds_asked++;
          end
        end else if (r < 85 || need > 200) begin
          len = $urandom_range(1, (need < 40) ? need : 40);
        end else begin
          len = $urandom_range(1, 12);
        end
        for (i = 0; i < len && sent_bytes < BYTE_TARGET; i++) begin
          r = $urandom_range(0, 99);
          if (r < 8)       d = 8'hFF;
          else if (r < 16) d = 8'h00;
          else             d = 8'($urandom_range(0, 255));
          lst = (i + 1 == len);
          // Noise frames scatter last flags at random.
          if (len <= 12 && $urandom_range(0, 5) == 0) lst = 1'b1;
          offer_byte(d, lst, pick_gap(), 1'b0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
